// ----- sv/irct_pkg.sv -----
// ----------------------------------------------------------------------------
// irct_pkg: shared types and codes for the interval reservation table
// Item kinds, status codes and the broadcast bus that runs along the cells.
// ----------------------------------------------------------------------------
package irct_pkg;

    localparam int unsigned DEF_TABLE_ENTRIES = 64;

    typedef enum logic [2:0] {
        K_INST_READ  = 3'd0,
        K_INST_WRITE = 3'd1,
        K_CHK_READ   = 3'd2,
        K_CHK_WRITE  = 3'd3,
        K_MARK       = 3'd4,
        K_RELEASE    = 3'd5,
        K_CLEAR      = 3'd6,
        K_NONE       = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_WRITE_VS_READ  = 3'd1,
        ST_WRITE_VS_WRITE = 3'd2,
        ST_READ_VS_WRITE  = 3'd3,
        ST_FULL           = 3'd4,
        ST_NOT_FOUND      = 3'd5
    } t_status;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] txn_id;
        logic [63:0] key;
        logic [63:0] time_from;
        logic [63:0] time_to;
    } t_req;

    // Per-cell flags handed to the collector
    typedef struct packed {
        logic free;
        logic own;
        logic rd_hit;
        logic wr_hit;
    } t_cell_flags;

    // Flags carried along the chain (ripple to the next cell)
    typedef struct packed {
        logic taken;
        logic found;
        logic rd_hit;
        logic wr_hit;
    } t_chain;

endpackage

// ----- sv/irct_if.sv -----
// ----------------------------------------------------------------------------
// irct_if: valid/ready channel
// Carries one beat of payload of the given type.
// ----------------------------------------------------------------------------
interface irct_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/irct_cell.sv -----
// ----------------------------------------------------------------------------
// irct_cell: one table entry
// Holds an entry, compares it with the registered request, then applies the
// update. Taken, found and hit flags ripple to the next cell.
// ----------------------------------------------------------------------------
module irct_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  irct_pkg::t_req  i_req,
    input  logic            i_cmp,
    input  logic            i_upd,
    input  irct_pkg::t_chain i_chain,
    output irct_pkg::t_chain o_chain
);
    import irct_pkg::*;

    logic        r_valid, r_pending, r_is_write;
    logic [63:0] r_txn, r_key, r_from, r_to;
    logic        r_free, r_own, r_rd, r_wr;
    logic        n_free, n_own, n_rd, n_wr, foreign;
    logic        is_inst, take;

    // compare stage
    always_comb begin
        n_free  = !r_valid;
        n_own   = r_valid && (r_txn == i_req.txn_id);
        foreign = r_valid && (r_txn != i_req.txn_id) && (r_key == i_req.key);
        n_rd = 1'b0;
        n_wr = 1'b0;
        if (t_kind'(i_req.kind) == K_CHK_READ) begin
            n_wr = foreign && r_is_write && (r_from <= i_req.time_from)
                   && (i_req.time_from < r_to);
        end else begin
            n_rd = foreign && !r_is_write && (i_req.time_from <= r_from)
                   && (r_from < i_req.time_to);
            n_wr = foreign && r_is_write && (i_req.time_from < r_to)
                   && (r_from < i_req.time_to);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmp) begin
            r_free <= n_free;
            r_own  <= n_own;
            r_rd   <= n_rd;
            r_wr   <= n_wr;
        end
    end

    assign is_inst = (t_kind'(i_req.kind) == K_INST_READ) ||
                     (t_kind'(i_req.kind) == K_INST_WRITE);
    assign take    = is_inst && r_free && !i_chain.taken;

    assign o_chain.taken  = i_chain.taken || r_free;
    assign o_chain.found  = i_chain.found || r_own;
    assign o_chain.rd_hit = i_chain.rd_hit || r_rd;
    assign o_chain.wr_hit = i_chain.wr_hit || r_wr;

    // update stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_pending <= 1'b0;
        end else if (i_upd) begin
            unique case (t_kind'(i_req.kind))
                K_INST_READ, K_INST_WRITE: begin
                    if (take) begin
                        r_valid   <= 1'b1;
                        r_pending <= 1'b0;
                    end
                end
                K_MARK: begin
                    if (r_own) r_pending <= 1'b1;
                end
                K_RELEASE: begin
                    if (r_own) begin
                        r_valid   <= 1'b0;
                        r_pending <= 1'b0;
                    end
                end
                K_CLEAR: begin
                    r_valid   <= 1'b0;
                    r_pending <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd && take) begin
            r_txn      <= i_req.txn_id;
            r_key      <= i_req.key;
            r_from     <= i_req.time_from;
            r_to       <= (t_kind'(i_req.kind) == K_INST_WRITE) ? i_req.time_to : 64'd0;
            r_is_write <= (t_kind'(i_req.kind) == K_INST_WRITE);
        end
    end
endmodule

// ----- sv/interval_reservation_conflict_table.sv -----
// ----------------------------------------------------------------------------
// interval_reservation_conflict_table: reservation table with conflict check
// Installs, checks, marks, releases and clears interval reservations.
// ----------------------------------------------------------------------------
// The request is registered, then every entry cell compares against it in
// parallel, then the cells update and the status beat is formed from flags
// rippled along the chain of TABLE_ENTRIES cells. A new item is taken only
// after the previous one has updated, and only while the output register is
// free or being drained. A waiting status beat holds off the next item. No
// clearing pass is needed after reset.
module interval_reservation_conflict_table #(
    parameter int unsigned TABLE_ENTRIES = irct_pkg::DEF_TABLE_ENTRIES
) (
    input logic i_clk,
    input logic i_rst_n,
    irct_if.sink   in_ch,
    irct_if.source out_ch
);
    import irct_pkg::*;

    t_req   r_req;
    logic   r_busy, r_cmp_done, r_out_valid;
    t_status r_status, n_status;
    t_chain chain [TABLE_ENTRIES+1];
    logic   accept, upd;

    assign in_ch.ready  = !r_busy && (!r_out_valid || out_ch.ready);
    assign accept       = in_ch.valid && in_ch.ready;
    assign upd          = r_busy && r_cmp_done;
    assign out_ch.valid = r_out_valid;
    assign out_ch.data  = r_status;

    always_ff @(posedge i_clk) begin
        if (accept) r_req <= in_ch.data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cmp_done  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (upd) r_out_valid <= 1'b1;
            else if (out_ch.ready) r_out_valid <= 1'b0;
            if (accept) begin
                r_busy     <= 1'b1;
                r_cmp_done <= 1'b0;
            end else if (r_busy && !r_cmp_done) begin
                r_cmp_done <= 1'b1;
            end else if (upd) begin
                r_busy      <= 1'b0;
                r_cmp_done  <= 1'b0;
            end
        end
    end

    assign chain[0] = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        irct_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_req   (r_req),
            .i_cmp   (r_busy && !r_cmp_done),
            .i_upd   (upd),
            .i_chain (chain[g]),
            .o_chain (chain[g+1])
        );
    end

    always_comb begin
        n_status = ST_OK;
        case (t_kind'(r_req.kind))
            K_INST_READ, K_INST_WRITE:
                n_status = chain[TABLE_ENTRIES].taken ? ST_OK : ST_FULL;
            K_CHK_READ:
                n_status = chain[TABLE_ENTRIES].wr_hit ? ST_READ_VS_WRITE : ST_OK;
            K_CHK_WRITE: begin
                if (chain[TABLE_ENTRIES].rd_hit)      n_status = ST_WRITE_VS_READ;
                else if (chain[TABLE_ENTRIES].wr_hit) n_status = ST_WRITE_VS_WRITE;
            end
            K_MARK:
                n_status = chain[TABLE_ENTRIES].found ? ST_OK : ST_NOT_FOUND;
            default: n_status = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (upd) r_status <= n_status;
    end
endmodule

// ----- verif/interval_reservation_conflict_table_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// interval_reservation_conflict_table_test: self-checking bench for the table
// Walks a short table of directed beats, then a table-filling pass and random
// traffic under several idle/stall mixes. A behavioral copy of the table
// predicts the beats that rows leave FREE; all are checked in order against the output.
// ----------------------------------------------------------------------------
module interval_reservation_conflict_table_test;
    import irct_pkg::*;

    localparam int unsigned ENTRIES = DEF_TABLE_ENTRIES;
    localparam int          FREE    = -1;   // status left to the predictor

    typedef struct {
        t_req req;
        int   status;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    irct_if #(.T(t_req))    in_ch ();
    irct_if #(.T(t_status)) out_ch ();

    interval_reservation_conflict_table #(.TABLE_ENTRIES(ENTRIES)) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // table copy
    bit          tb_valid   [ENTRIES];
    bit          tb_write   [ENTRIES];
    bit          tb_pending [ENTRIES];
    logic [63:0] tb_txn     [ENTRIES];
    logic [63:0] tb_key     [ENTRIES];
    logic [63:0] tb_from    [ENTRIES];
    logic [63:0] tb_to      [ENTRIES];

    t_status status_q[$];
    t_row    rows[$];
    int      typed_status = FREE;
    int      idle_pct     = 0;
    int      stall_pct    = 0;
    int      hold_cycles  = 0;
    bit      failed       = 0;

    function automatic t_status predict_status(t_req r);
        t_status st;
        bit      rd_hit;
        bit      wr_hit;
        bit      done;
        st     = ST_OK;
        rd_hit = 0;
        wr_hit = 0;
        done   = 0;
        case (t_kind'(r.kind))
            K_INST_READ, K_INST_WRITE: begin
                st = ST_FULL;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!done && !tb_valid[i]) begin
                        done          = 1;
                        st            = ST_OK;
                        tb_valid[i]   = 1;
                        tb_write[i]   = (r.kind == K_INST_WRITE);
                        tb_pending[i] = 0;
                        tb_txn[i]     = r.txn_id;
                        tb_key[i]     = r.key;
                        tb_from[i]    = r.time_from;
                        tb_to[i]      = tb_write[i] ? r.time_to : 64'd0;
                    end
                end
            end
            K_CHK_READ, K_CHK_WRITE: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (tb_valid[i] && tb_txn[i] != r.txn_id && tb_key[i] == r.key) begin
                        if (r.kind == K_CHK_READ) begin
                            if (tb_write[i] && tb_from[i] <= r.time_from
                                    && r.time_from < tb_to[i])
                                wr_hit = 1;
                        end else if (tb_write[i]) begin
                            if (r.time_from < tb_to[i] && tb_from[i] < r.time_to)
                                wr_hit = 1;
                        end else if (r.time_from <= tb_from[i] && tb_from[i] < r.time_to) begin
                            rd_hit = 1;
                        end
                    end
                end
                if (r.kind == K_CHK_READ)
                    st = wr_hit ? ST_READ_VS_WRITE : ST_OK;
                else
                    st = rd_hit ? ST_WRITE_VS_READ : (wr_hit ? ST_WRITE_VS_WRITE : ST_OK);
            end
            K_MARK: begin
                st = ST_NOT_FOUND;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (tb_valid[i] && tb_txn[i] == r.txn_id) begin
                        tb_pending[i] = 1;
                        st            = ST_OK;
                    end
                end
            end
            K_RELEASE: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (tb_valid[i] && tb_txn[i] == r.txn_id) begin
                        tb_valid[i]   = 0;
                        tb_pending[i] = 0;
                    end
                end
            end
            K_CLEAR: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    tb_valid[i]   = 0;
                    tb_pending[i] = 0;
                end
            end
            default: st = ST_OK;
        endcase
        return st;
    endfunction

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // accepted beats
    always @(posedge i_clk) begin
        t_status st;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            st = predict_status(in_ch.data);
            if (typed_status != FREE)
                st = t_status'(typed_status);
            status_q.insert(status_q.size(), st);
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (status_q.size() == 0) begin
                $error("status: nothing expected, actual %0d", out_ch.data);
                failed = 1;
            end else begin
                st = status_q.pop_front();
                if (out_ch.data !== st) begin
                    $error("status: expected %0d, actual %0d", st, out_ch.data);
                    failed = 1;
                end
            end
        end
    end

    // receiver
    initial begin
        out_ch.ready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_ch.ready <= 0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_beat(t_req r, int status);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            in_ch.valid <= 0;
        end
        @(negedge i_clk);
        in_ch.valid  <= 1;
        in_ch.data   <= r;
        typed_status <= status;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic add_row(t_kind k, logic [63:0] txn, logic [63:0] key,
                           logic [63:0] t0, logic [63:0] t1, int status);
        t_row row;
        row.req    = '{kind: k, txn_id: txn, key: key, time_from: t0, time_to: t1};
        row.status = status;
        rows.insert(rows.size(), row);
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 0;
        while (status_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [63:0] pick_wide(int unsigned small_max);
        case ($urandom_range(9))
            0:       return '1;
            1:       return {$urandom, $urandom};
            2:       return 64'hFFFF_FFFF_FFFF_FFF0 + 64'($urandom_range(15));
            default: return 64'($urandom_range(small_max));
        endcase
    endfunction

    function automatic t_req random_req();
        t_req r;
        int   pick;
        pick = $urandom_range(99);
        if (pick < 20)      r.kind = K_INST_READ;
        else if (pick < 40) r.kind = K_INST_WRITE;
        else if (pick < 58) r.kind = K_CHK_READ;
        else if (pick < 76) r.kind = K_CHK_WRITE;
        else if (pick < 86) r.kind = K_MARK;
        else if (pick < 95) r.kind = K_RELEASE;
        else if (pick < 97) r.kind = K_CLEAR;
        else                r.kind = K_NONE;
        r.txn_id    = ($urandom_range(7) == 0) ? pick_wide(5) : 64'($urandom_range(4));
        r.key       = ($urandom_range(7) == 0) ? pick_wide(3) : 64'($urandom_range(2));
        r.time_from = pick_wide(20);
        r.time_to   = ($urandom_range(5) == 0) ? pick_wide(20)
                                               : r.time_from + 64'($urandom_range(8));
        return r;
    endfunction

    initial begin
        t_req r;
        i_rst_n      = 0;
        in_ch.valid  = 0;
        in_ch.data   = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        add_row(K_CHK_READ,   64'd1, 64'd0, 64'd0, 64'd0, ST_OK);
        add_row(K_MARK,       '1,    64'd0, 64'd0, 64'd0, ST_NOT_FOUND);
        add_row(K_RELEASE,    64'd0, 64'd0, 64'd0, 64'd0, ST_OK);
        add_row(K_INST_WRITE, 64'd1, '1,    64'd0, '1,    ST_OK);
        add_row(K_INST_READ,  64'd2, '1,    '1,    '1,    ST_OK);
        add_row(K_CHK_READ,   64'd3, '1,    '1 - 64'd1, 64'd0, ST_READ_VS_WRITE);
        add_row(K_CHK_READ,   64'd3, '1,    '1,    64'd0, ST_OK);
        add_row(K_CHK_WRITE,  64'd3, '1,    '1,    '1,    ST_OK);
        add_row(K_CHK_WRITE,  64'd3, '1,    64'd5, '1,    ST_WRITE_VS_WRITE);
        add_row(K_CHK_WRITE,  64'd1, '1,    64'd0, '1,    FREE);
        add_row(K_INST_READ,  64'd2, '1,    64'd10, 64'd0, ST_OK);
        add_row(K_CHK_WRITE,  64'd3, '1,    64'd10, 64'd11, ST_WRITE_VS_READ);
        add_row(K_INST_WRITE, 64'd4, 64'd7, 64'd9, 64'd3, ST_OK);
        add_row(K_CHK_READ,   64'd5, 64'd7, 64'd5, 64'd0, ST_OK);
        add_row(K_CHK_WRITE,  64'd5, 64'd7, 64'd0, '1,    FREE);
        add_row(K_MARK,       64'd2, 64'd0, 64'd0, 64'd0, ST_OK);
        add_row(K_CHK_WRITE,  64'd3, '1,    64'd10, 64'd11, FREE);
        add_row(K_NONE,       '1,    '1,    '1,    '1,    ST_OK);
        add_row(K_RELEASE,    64'd2, 64'd0, 64'd0, 64'd0, ST_OK);
        add_row(K_CHK_WRITE,  64'd3, '1,    64'd10, 64'd11, ST_WRITE_VS_WRITE);
        add_row(K_CLEAR,      64'd0, 64'd0, 64'd0, 64'd0, ST_OK);
        add_row(K_CHK_READ,   64'd3, '1,    64'd5, 64'd0, ST_OK);
        foreach (rows[i]) send_beat(rows[i].req, rows[i].status);
        drain();

        // fill the table past full while the receiver holds off
        hold_cycles = 300;
        for (int i = 0; i < ENTRIES + 3; i++) begin
            r = '{kind: K_INST_WRITE, txn_id: 64'(i % 5), key: 64'(i % 3),
                  time_from: 64'(i), time_to: 64'(i + 4)};
            send_beat(r, FREE);
        end
        r = '{kind: K_MARK, txn_id: 64'd4, key: '0, time_from: '0, time_to: '0};
        send_beat(r, ST_OK);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            idle_pct  = (phase == 1 || phase == 3) ? (phase == 3 ? 20 : 81) : 0;
            stall_pct = (phase == 2 || phase == 3) ? (phase == 3 ? 20 : 81) : 0;
            for (int n = 0; n < 85; n++) send_beat(random_req(), FREE);
            drain();
        end
        idle_pct  = 0;
        stall_pct = 0;

        repeat (20) @(posedge i_clk);
        if (!failed && status_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ----- filelist.f -----
sv/irct_pkg.sv
sv/irct_if.sv
sv/irct_cell.sv
sv/interval_reservation_conflict_table.sv
verif/interval_reservation_conflict_table_test.sv
